>>> src/ryuv_pkg.sv
// ----------------------------------------------------------------------------
// RGB to YUV 4:2:0 stream package
// Shared widths, register indexes, conversion coefficients and flag types.
// ----------------------------------------------------------------------------
package ryuv_pkg;

    // Default width of the column and row counters.
    localparam int DIM_BITS_DEFAULT = 12;

    // Configuration port.
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 13'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

    // Sample width and the width of the biased weighted sums.
    localparam int PIX_W = 8;
    localparam int SUM_W = 16;

    // BT.601 integer weights, stored as magnitudes; signs are applied in the sums.
    localparam int Y_R  = 66;
    localparam int Y_G  = 129;
    localparam int Y_B  = 25;
    localparam int CB_R = 38;
    localparam int CB_G = 74;
    localparam int CB_B = 112;
    localparam int CR_R = 112;
    localparam int CR_G = 94;
    localparam int CR_B = 18;

    // Offsets, added before the divide by 256.
    localparam int LUMA_OFFSET   = 16;
    localparam int CHROMA_OFFSET = 128;
    localparam int FRAC_BITS     = 8;

    // Position flags that travel with each pixel.
    typedef struct packed {
        logic chroma_valid;
        logic line_end;
        logic frame_end;
    } pos_flags_t;

endpackage

>>> src/ryuv_raster_ctr.sv
// ----------------------------------------------------------------------------
// Raster position counter
// Tracks column and row of the next pixel and flags chroma sites, line end
// and frame end against the configured frame size.
// ----------------------------------------------------------------------------
module ryuv_raster_ctr #(
    parameter int DIM_BITS = ryuv_pkg::DIM_BITS_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        advance,
    input  logic [ryuv_pkg::CFG_W-1:0]  frame_width,
    input  logic [ryuv_pkg::CFG_W-1:0]  frame_height,
    output ryuv_pkg::pos_flags_t        flags
);

    // Wide enough for both the configured value and 2^DIM_BITS.
    localparam int CMP_W = (DIM_BITS + 1 > ryuv_pkg::CFG_W) ? DIM_BITS + 1 : ryuv_pkg::CFG_W;

    logic [DIM_BITS-1:0] col_reg, col_next;
    logic [DIM_BITS-1:0] row_reg, row_next;
    logic [DIM_BITS-1:0] last_col;
    logic [DIM_BITS-1:0] last_row;
    logic                line_end;
    logic                frame_end;

    // Last position of a dimension after limiting it to 1 .. 2^DIM_BITS.
    function automatic logic [DIM_BITS-1:0] last_pos(input logic [ryuv_pkg::CFG_W-1:0] dim);
        logic [CMP_W-1:0] dim_ext;
        logic [CMP_W-1:0] dim_max;
        dim_ext = CMP_W'(dim);
        dim_max = CMP_W'(1) << DIM_BITS;
        if (dim_ext == '0) begin
            last_pos = '0;
        end else if (dim_ext > dim_max) begin
            last_pos = '1;
        end else begin
            last_pos = DIM_BITS'(dim_ext - CMP_W'(1));
        end
    endfunction

    assign last_col  = last_pos(frame_width);
    assign last_row  = last_pos(frame_height);
    // A counter at or past the last position ends the line, which also
    // covers a frame size that shrank while a frame was in flight.
    assign line_end  = (col_reg >= last_col);
    assign frame_end = line_end && (row_reg >= last_row);

    assign flags.chroma_valid = !col_reg[0] && !row_reg[0];
    assign flags.line_end     = line_end;
    assign flags.frame_end    = frame_end;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (advance) begin
            if (line_end) begin
                col_next = '0;
                row_next = frame_end ? '0 : row_reg + DIM_BITS'(1);
            end else begin
                col_next = col_reg + DIM_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

>>> src/ryuv_csc.sv
// ----------------------------------------------------------------------------
// Color space conversion
// BT.601 integer RGB to Y, Cb and Cr for one pixel.
// ----------------------------------------------------------------------------
module ryuv_csc (
    input  logic [ryuv_pkg::PIX_W-1:0] red,
    input  logic [ryuv_pkg::PIX_W-1:0] green,
    input  logic [ryuv_pkg::PIX_W-1:0] blue,
    output logic [ryuv_pkg::PIX_W-1:0] luma,
    output logic [ryuv_pkg::PIX_W-1:0] chroma_blue,
    output logic [ryuv_pkg::PIX_W-1:0] chroma_red
);

    localparam int SUM_W = ryuv_pkg::SUM_W;
    localparam int FB    = ryuv_pkg::FRAC_BITS;

    logic [SUM_W-1:0] y_sum;
    logic [SUM_W-1:0] cb_sum;
    logic [SUM_W-1:0] cr_sum;

    // With the offset folded in, every sum stays within 0 .. 2^16-1 for any
    // input, so modular arithmetic gives the exact floored result and no
    // clamping is needed.
    assign y_sum = SUM_W'(ryuv_pkg::Y_R * red + ryuv_pkg::Y_G * green + ryuv_pkg::Y_B * blue
                          + (ryuv_pkg::LUMA_OFFSET << FB));
    assign cb_sum = SUM_W'(ryuv_pkg::CB_B * blue - ryuv_pkg::CB_R * red
                           - ryuv_pkg::CB_G * green + (ryuv_pkg::CHROMA_OFFSET << FB));
    assign cr_sum = SUM_W'(ryuv_pkg::CR_R * red - ryuv_pkg::CR_G * green
                           - ryuv_pkg::CR_B * blue + (ryuv_pkg::CHROMA_OFFSET << FB));

    assign luma        = y_sum[SUM_W-1:FB];
    assign chroma_blue = cb_sum[SUM_W-1:FB];
    assign chroma_red  = cr_sum[SUM_W-1:FB];

endmodule

>>> src/rgb_to_yuv420_stream_unit.sv
// ----------------------------------------------------------------------------
// RGB to YUV 4:2:0 stream unit
// Converts a raster stream of RGB pixels to BT.601 luma, with chroma taken
// from the top-left pixel of every 2x2 block, and marks line and frame ends.
// ----------------------------------------------------------------------------
//
//  Channel  Ports                           Direction  One request carries
//  -------  ------------------------------  ---------  ---------------------------
//  input    s_valid/s_ready, s_*            in         one RGB pixel
//  result   m_valid/m_ready, m_*            out        Y, Cb, Cr and position flags
//  config   cfg_wr_en, cfg_wr_index/data    in         one register write
//
// Each pixel passes through the input register and then the result register,
// with the color math between them. While the result side does not stall, a
// new pixel can be accepted every cycle, a sustained rate of one pixel per clock.
// Reset (aresetn low at a clock edge) empties both registers, zeroes the
// raster counters and restores a 640x480 frame size.
// When the result side stalls, the input register still takes a pixel as long
// as it is empty, so a finished result and a pending pixel can sit together.
//
module rgb_to_yuv420_stream_unit #(
    parameter int DIM_BITS = ryuv_pkg::DIM_BITS_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    // Configuration writes.
    input  logic                            cfg_wr_en,
    input  logic [ryuv_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [ryuv_pkg::CFG_W-1:0]      cfg_wr_data,

    // Pixel input.
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [ryuv_pkg::PIX_W-1:0]      s_red,
    input  logic [ryuv_pkg::PIX_W-1:0]      s_green,
    input  logic [ryuv_pkg::PIX_W-1:0]      s_blue,

    // Converted output.
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [ryuv_pkg::PIX_W-1:0]      m_luma,
    output logic [ryuv_pkg::PIX_W-1:0]      m_chroma_blue,
    output logic [ryuv_pkg::PIX_W-1:0]      m_chroma_red,
    output logic                            m_chroma_valid,
    output logic                            m_line_end,
    output logic                            m_frame_end
);

    // Frame size registers.
    logic [ryuv_pkg::CFG_W-1:0]     frame_width_reg;
    logic [ryuv_pkg::CFG_W-1:0]     frame_height_reg;

    // Input register: the accepted pixel and its position flags.
    logic                           in_valid_reg;
    logic [ryuv_pkg::PIX_W-1:0]     red_reg;
    logic [ryuv_pkg::PIX_W-1:0]     green_reg;
    logic [ryuv_pkg::PIX_W-1:0]     blue_reg;
    ryuv_pkg::pos_flags_t           flags_reg;

    // Result register.
    logic                           out_valid_reg;
    logic [ryuv_pkg::PIX_W-1:0]     luma_reg;
    logic [ryuv_pkg::PIX_W-1:0]     cb_reg;
    logic [ryuv_pkg::PIX_W-1:0]     cr_reg;
    ryuv_pkg::pos_flags_t           out_flags_reg;

    ryuv_pkg::pos_flags_t           pos_flags;
    logic [ryuv_pkg::PIX_W-1:0]     luma_calc;
    logic [ryuv_pkg::PIX_W-1:0]     cb_calc;
    logic [ryuv_pkg::PIX_W-1:0]     cr_calc;
    logic                           in_accept;
    logic                           out_load;
    logic                           out_free;

    // ------------------------------------------------------------------
    // Configuration. Writes to an unknown index are dropped.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= ryuv_pkg::FRAME_WIDTH_RESET;
            frame_height_reg <= ryuv_pkg::FRAME_HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                ryuv_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wr_data;
                ryuv_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake. The result register is free when it is empty or being
    // drained this cycle; the input register then moves forward, which in
    // turn frees it for a new request.
    // ------------------------------------------------------------------
    assign out_free  = !out_valid_reg || m_ready;
    assign out_load  = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || out_free;
    assign in_accept = s_valid && s_ready;

    // The position counter advances once per accepted pixel; its flags
    // describe the pixel being accepted and are latched along with it.
    ryuv_raster_ctr #(
        .DIM_BITS (DIM_BITS)
    ) u_raster_ctr (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (in_accept),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .flags        (pos_flags)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            red_reg   <= s_red;
            green_reg <= s_green;
            blue_reg  <= s_blue;
            flags_reg <= pos_flags;
        end
    end

    // ------------------------------------------------------------------
    // Color math between the two registers.
    // ------------------------------------------------------------------
    ryuv_csc u_csc (
        .red         (red_reg),
        .green       (green_reg),
        .blue        (blue_reg),
        .luma        (luma_calc),
        .chroma_blue (cb_calc),
        .chroma_red  (cr_calc)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // Chroma reads as zero on pixels that carry no chroma sample.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            luma_reg      <= luma_calc;
            cb_reg        <= flags_reg.chroma_valid ? cb_calc : '0;
            cr_reg        <= flags_reg.chroma_valid ? cr_calc : '0;
            out_flags_reg <= flags_reg;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_luma         = luma_reg;
    assign m_chroma_blue  = cb_reg;
    assign m_chroma_red   = cr_reg;
    assign m_chroma_valid = out_flags_reg.chroma_valid;
    assign m_line_end     = out_flags_reg.line_end;
    assign m_frame_end    = out_flags_reg.frame_end;

`ifndef SYNTHESIS
    // The last pixel of a frame is always the last pixel of its line.
    a_frame_end_is_line_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_end |-> m_line_end)
        else $error("frame end without line end");

    // Pixels without a chroma site deliver zero chroma.
    a_chroma_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_chroma_valid |-> (m_chroma_blue == '0) && (m_chroma_red == '0))
        else $error("chroma present on a pixel without a chroma site");

    // A pixel in the input register that cannot move stays there.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_free |=> in_valid_reg)
        else $error("pending pixel dropped from the input register");

    // A stalled result keeps its request.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_luma))
        else $error("stalled result changed");
`endif

endmodule
